// ===== rtl/tcd_pkg.sv =====
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types, constants and the hash helper of the tile change detector.
// ----------------------------------------------------------------------------
package tcd_pkg;

    localparam int MAX_TILES  = 2048;
    localparam int TILE_IDX_W = $clog2(MAX_TILES);
    localparam int TCNT_W     = 12;
    localparam int HASH_W     = 32;
    localparam int ENTRY_W    = HASH_W + 1;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811c_9dc5;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

    typedef enum logic {
        KIND_HASH    = 1'b0,
        KIND_CONSUME = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [TILE_IDX_W-1:0] idx;
        logic [HASH_W-1:0]     hash;
    } t_s1_req;

    typedef struct packed {
        t_kind                 kind;
        logic [TILE_IDX_W-1:0] idx;
        logic [HASH_W-1:0]     hash;
        logic                  changed;
        logic                  dirty_was_set;
    } t_result;

    typedef struct packed {
        logic                  en;
        logic [TILE_IDX_W-1:0] addr;
        logic [ENTRY_W-1:0]    data;
    } t_wr_req;

    // multiply by the fnv prime (2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1)
    function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
        return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// ===== rtl/tcd_ram.sv =====
// ----------------------------------------------------------------------------
// tcd_ram
// Per-tile store: dirty bit over stored hash, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module tcd_ram
    import tcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [TILE_IDX_W-1:0] i_rd_addr,
    output logic [ENTRY_W-1:0]    o_rd_data,
    input  t_wr_req               i_wr
);

    logic [ENTRY_W-1:0] r_mem [MAX_TILES];
    logic [ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/tcd_hash.sv =====
// ----------------------------------------------------------------------------
// tcd_hash
// Running fnv-1a hash over the pixels of the current tile.
// ----------------------------------------------------------------------------
module tcd_hash
    import tcd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pixel_en,
    input  logic              i_last,
    input  logic [HASH_W-1:0] i_pixel,
    output logic [HASH_W-1:0] o_closed_hash
);

    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] n_hash;
    logic [HASH_W-1:0] mixed;

    assign mixed         = fnv_mul(r_hash ^ i_pixel);
    assign o_closed_hash = (mixed == '0) ? HASH_W'(1) : mixed;

    always_comb begin
        n_hash = r_hash;
        if (i_pixel_en) begin
            n_hash = i_last ? FNV_BASIS : mixed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
        end else begin
            r_hash <= n_hash;
        end
    end

endmodule

// ===== rtl/tcd_rmw.sv =====
// ----------------------------------------------------------------------------
// tcd_rmw
// Read-modify-write stage on the tile store, with write forwarding and the
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module tcd_rmw
    import tcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_s1_req               i_req,
    input  logic                  i_advance,
    input  logic [TCNT_W-1:0]     i_active_tiles,
    output logic                  o_s1_valid,
    output t_result               o_result,
    output logic                  o_clr_busy,
    output logic                  o_rd_en,
    output logic [TILE_IDX_W-1:0] o_rd_addr,
    input  logic [ENTRY_W-1:0]    i_rd_data,
    output t_wr_req               o_wr
);

    logic                  r_s1_valid;
    t_s1_req               r_s1;
    logic                  r_byp_valid;
    logic [ENTRY_W-1:0]    r_byp_data;
    logic                  r_clr_busy;
    logic [TILE_IDX_W-1:0] r_clr_addr;

    logic [ENTRY_W-1:0]    entry;
    logic [HASH_W-1:0]     stored_hash;
    logic                  stored_dirty;
    logic                  in_use;
    logic                  changed;
    logic                  is_consume;

    assign entry        = r_byp_valid ? r_byp_data : i_rd_data;
    assign stored_hash  = entry[HASH_W-1:0];
    assign stored_dirty = entry[HASH_W];
    assign is_consume   = (r_s1.kind == KIND_CONSUME);
    assign in_use       = ({1'b0, r_s1.idx} < i_active_tiles);
    assign changed      = !is_consume && in_use && (stored_hash != r_s1.hash);

    always_comb begin
        o_result.kind          = r_s1.kind;
        o_result.idx           = r_s1.idx;
        o_result.hash          = is_consume ? HASH_W'(1) : r_s1.hash;
        o_result.changed       = changed;
        o_result.dirty_was_set = is_consume && stored_dirty;
    end

    always_comb begin
        if (r_clr_busy) begin
            o_wr.en   = 1'b1;
            o_wr.addr = r_clr_addr;
            o_wr.data = '0;
        end else begin
            o_wr.en   = r_s1_valid && i_advance && (is_consume || changed);
            o_wr.addr = r_s1.idx;
            o_wr.data = is_consume ? {1'b0, stored_hash} : {1'b1, r_s1.hash};
        end
    end

    assign o_rd_en    = i_load;
    assign o_rd_addr  = i_req.idx;
    assign o_s1_valid = r_s1_valid;
    assign o_clr_busy = r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_byp_valid <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            if (i_advance) begin
                r_s1_valid <= i_load;
            end
            if (i_load) begin
                r_byp_valid <= o_wr.en && !r_clr_busy && (o_wr.addr == i_req.idx);
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == TILE_IDX_W'(MAX_TILES - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1       <= i_req;
            r_byp_data <= o_wr.data;
        end
    end

endmodule

// ===== rtl/tile_change_detector.sv =====
// ----------------------------------------------------------------------------
// tile_change_detector
// Per-tile fnv-1a hash of streamed pixels, compared against a stored hash per
// tile to keep dirty bits; consume requests read and clear a dirty bit.
//
//   channel   direction  signals                       request contents
//   s_axis    in         tvalid tready tdata tuser     pixel or consume
//                        tlast
//   m_axis    out        tvalid tready tdata tuser     hash or consume result
//   cfg       in         valid ready data              active tile count
//
// One request per cycle while s_axis_tready is high; a result is registered in
// the read-modify-write stage, then in the output register. The store is read
// on a last pixel or consume and written back as that stage advances; a write
// to the tile read in the same cycle is forwarded. After reset all 2048 entries
// are swept to zero with s_axis_tready low; cfg writes are taken at any time.
// A stalled result holds the read-modify-write stage and s_axis_tready.
// ----------------------------------------------------------------------------
module tile_change_detector
    import tcd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // pixel_word, tile_index
    input  logic                 s_axis_tuser,  // command
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // result_index, final_hash, tile_changed, dirty_was_set
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tuser,  // result_kind
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [TCNT_W-1:0]    i_cfg_data
);

    logic [TCNT_W-1:0]     r_active_tiles;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  accept;
    logic                  advance;
    logic                  is_consume;
    logic                  s1_load;
    logic                  s1_valid;
    logic                  clr_busy;
    logic [HASH_W-1:0]     pixel;
    logic [TILE_IDX_W-1:0] idx;
    logic [HASH_W-1:0]     closed_hash;
    t_s1_req               s1_req;
    t_result               result;
    logic                  rd_en;
    logic [TILE_IDX_W-1:0] rd_addr;
    logic [ENTRY_W-1:0]    rd_data;
    t_wr_req               wr;

    assign pixel      = s_axis_tdata[HASH_W-1:0];
    assign idx        = s_axis_tdata[HASH_W +: TILE_IDX_W];
    assign is_consume = (t_kind'(s_axis_tuser) == KIND_CONSUME);

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !clr_busy && advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s1_load       = accept && (is_consume || s_axis_tlast);
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        s1_req.kind = t_kind'(s_axis_tuser);
        s1_req.idx  = idx;
        s1_req.hash = closed_hash;
    end

    tcd_hash u_hash (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_en    (accept && !is_consume),
        .i_last        (s_axis_tlast),
        .i_pixel       (pixel),
        .o_closed_hash (closed_hash)
    );

    tcd_rmw u_rmw (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (s1_load),
        .i_req          (s1_req),
        .i_advance      (advance),
        .i_active_tiles (r_active_tiles),
        .o_s1_valid     (s1_valid),
        .o_result       (result),
        .o_clr_busy     (clr_busy),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_wr           (wr)
    );

    tcd_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_tiles <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_active_tiles <= i_cfg_data;
            end
            if (advance) begin
                r_out_valid <= s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && s1_valid) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = M_TDATA_W'({r_out.dirty_was_set, r_out.changed,
                                       r_out.hash, r_out.idx});

    // no request taken while the store is being swept
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !s_axis_tready)
        else $error("request accepted during store sweep");

    // a stalled stage keeps its request
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && !advance) |=> s1_valid)
        else $error("read-modify-write stage lost a request");

    a_consume_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_CONSUME) |->
            (r_out.hash == HASH_W'(1) && !r_out.changed))
        else $error("consume result carries hash fields");

    a_hash_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_HASH) |->
            (r_out.hash != '0 && !r_out.dirty_was_set))
        else $error("hash result malformed");

endmodule
